FILE: hdl/udp_rcd_pkg.sv
`timescale 1ns / 1ps

package udp_rcd_pkg;

    // Binding table
    localparam int NUM_SLOTS  = 4;
    localparam int PORT_REGS  = 4;
    localparam int SLOT_REGS  = (NUM_SLOTS < PORT_REGS) ? NUM_SLOTS : PORT_REGS;
    localparam int SLOT_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Header and pseudo-header
    localparam int HDR_BYTES    = 8;
    localparam int PSEUDO_BYTES = 12;
    localparam int FIXED_SUMMED = 6;
    localparam logic [15:0] PROTO_UDP = 16'd17;

    // Channel widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    typedef enum logic [2:0] {
        V_DELIVERED = 3'd0,
        V_SHORT     = 3'd1,
        V_BADLEN    = 3'd2,
        V_BADSUM    = 3'd3,
        V_NOBIND    = 3'd4
    } verdict_t;

    typedef struct packed {
        logic        last_byte;
        logic [31:0] dest_addr;
        logic [31:0] source_addr;
        logic [7:0]  seg_byte;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } port_match_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [SLOT_W-1:0] slot_hit;
        logic [15:0]       src_port_out;
        logic [15:0]       dst_port_out;
        logic [15:0]       payload_len;
    } result_t;

endpackage

FILE: hdl/udp_rcd_in_stage.sv
`timescale 1ns / 1ps

module udp_rcd_in_stage
    import udp_rcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 take,
    output in_item_t             item,
    output logic                 item_valid
);

    logic     valid_reg;
    in_item_t item_reg;

    // Refill when empty or whenever the held byte moves on in the same cycle
    assign s_tready   = !valid_reg || take;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.seg_byte    <= s_tdata[7:0];
            item_reg.source_addr <= s_tdata[39:8];
            item_reg.dest_addr   <= s_tdata[71:40];
            item_reg.last_byte   <= s_tlast;
        end
    end

endmodule

FILE: hdl/udp_rcd_port_table.sv
`timescale 1ns / 1ps

module udp_rcd_port_table
    import udp_rcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [15:0]           lookup_port,
    output port_match_t           match
);

    logic [15:0] bound_port_reg [SLOT_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_REGS; i++) begin
                bound_port_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            for (int i = 0; i < SLOT_REGS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    bound_port_reg[i] <= cfg_data[15:0];
                end
            end
        end
    end

    // Lowest bound slot wins; a free slot never matches
    always_comb begin
        match = '0;
        for (int i = SLOT_REGS - 1; i >= 0; i--) begin
            if (bound_port_reg[i] != 16'd0 && bound_port_reg[i] == lookup_port) begin
                match.hit  = 1'b1;
                match.slot = SLOT_W'(i);
            end
        end
    end

endmodule

FILE: hdl/udp_rcd_core.sv
`timescale 1ns / 1ps

module udp_rcd_core
    import udp_rcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  in_item_t    item,
    input  port_match_t match,
    output logic [15:0] lookup_port,
    output result_t     result
);

    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [15:0] ones_sum_reg, ones_sum_next;
    logic [7:0]  odd_high_reg, odd_high_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dport_reg, dport_next;
    logic [15:0] hdr_length_reg, hdr_length_next;
    logic [15:0] hdr_checksum_reg, hdr_checksum_next;

    logic        saturated;
    logic        sum_en;
    logic [18:0] pseudo_sum;
    logic [18:0] word_sum;
    logic [18:0] final_sum;
    logic [15:0] pad_word;
    logic [15:0] check_sum;

    // End-around carry fold of a short multi-operand sum
    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] t;
        t = 17'(s[15:0]) + 17'(s[18:16]);
        return t[15:0] + 16'(t[16]);
    endfunction

    always_comb begin
        bytes_seen_next   = bytes_seen_reg;
        ones_sum_next     = ones_sum_reg;
        odd_high_next     = odd_high_reg;
        src_port_next     = src_port_reg;
        dport_next        = dport_reg;
        hdr_length_next   = hdr_length_reg;
        hdr_checksum_next = hdr_checksum_reg;

        saturated  = (bytes_seen_reg == 16'hFFFF);
        sum_en     = !saturated && (bytes_seen_reg < 16'(FIXED_SUMMED)
                                    || bytes_seen_reg < hdr_length_reg);
        pseudo_sum = 19'(item.source_addr[31:16]) + 19'(item.source_addr[15:0])
                   + 19'(item.dest_addr[31:16]) + 19'(item.dest_addr[15:0])
                   + 19'(PROTO_UDP);
        word_sum   = 19'(ones_sum_reg) + 19'({odd_high_reg, item.seg_byte});

        if (!saturated) begin
            case (bytes_seen_reg)
                16'd0: src_port_next = {item.seg_byte, 8'h00};
                16'd1: src_port_next = {src_port_reg[15:8], item.seg_byte};
                16'd2: dport_next = {item.seg_byte, 8'h00};
                16'd3: dport_next = {dport_reg[15:8], item.seg_byte};
                16'd4: hdr_length_next = {item.seg_byte, 8'h00};
                16'd5: hdr_length_next = {hdr_length_reg[15:8], item.seg_byte};
                16'd6: hdr_checksum_next = {item.seg_byte, 8'h00};
                16'd7: hdr_checksum_next = {hdr_checksum_reg[15:8], item.seg_byte};
                default: ;
            endcase
            bytes_seen_next = bytes_seen_reg + 16'd1;
        end

        // First byte also folds in the address and protocol part of the pseudo-header
        if (bytes_seen_reg == 16'd0) begin
            ones_sum_next = oc_fold(pseudo_sum);
        end
        if (sum_en) begin
            if (!bytes_seen_reg[0]) begin
                odd_high_next = item.seg_byte;
            end else begin
                ones_sum_next = oc_fold(word_sum);
            end
        end

        // Odd length pads the dangling byte; the length word closes the pseudo-header
        pad_word  = hdr_length_next[0] ? {odd_high_next, 8'h00} : 16'h0000;
        final_sum = 19'(ones_sum_next) + 19'(pad_word) + 19'(hdr_length_next);
        check_sum = oc_fold(final_sum);

        result = '0;
        if (bytes_seen_next < 16'(HDR_BYTES)) begin
            result.verdict = V_SHORT;
        end else begin
            result.src_port_out = src_port_next;
            result.dst_port_out = dport_next;
            if (hdr_length_next < 16'(HDR_BYTES) || hdr_length_next > bytes_seen_next) begin
                result.verdict = V_BADLEN;
            end else begin
                result.payload_len = hdr_length_next - 16'(HDR_BYTES);
                if (hdr_checksum_next != 16'd0 && check_sum != 16'hFFFF) begin
                    result.verdict = V_BADSUM;
                end else if (match.hit) begin
                    result.verdict  = V_DELIVERED;
                    result.slot_hit = match.slot;
                end else begin
                    result.verdict = V_NOBIND;
                end
            end
        end
    end

    assign lookup_port = dport_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last_byte)) begin
            bytes_seen_reg   <= '0;
            ones_sum_reg     <= '0;
            odd_high_reg     <= '0;
            src_port_reg     <= '0;
            dport_reg        <= '0;
            hdr_length_reg   <= '0;
            hdr_checksum_reg <= '0;
        end else if (fire) begin
            bytes_seen_reg   <= bytes_seen_next;
            ones_sum_reg     <= ones_sum_next;
            odd_high_reg     <= odd_high_next;
            src_port_reg     <= src_port_next;
            dport_reg        <= dport_next;
            hdr_length_reg   <= hdr_length_next;
            hdr_checksum_reg <= hdr_checksum_next;
        end
    end

endmodule

FILE: hdl/udp_receive_check_demux.sv
`timescale 1ns / 1ps

// Channel  | Dir | Transfer                       | Payload
// ---------+-----+--------------------------------+--------------------------------------
// s_       | in  | one segment byte               | tdata: seg_byte, source_addr,
//          |     |                                |        dest_addr; tlast: last_byte
// m_       | out | one verdict per segment        | tdata: slot_hit, src_port_out,
//          |     |                                |        dst_port_out, payload_len;
//          |     |                                |        tuser: verdict
// cfg_     | in  | bound port write, index 0..3   | cfg_data[15:0]
//
// One byte per cycle unless a last byte is held: a byte sits in the input register,
// then one pass of ones-complement add, header capture and verdict logic updates
// the segment state. The verdict then drives m_tvalid from the result register.
// Reset (aresetn, synchronous) clears segment state and frees every slot.
// Bytes that end no segment keep flowing while a verdict waits on m_tready;
// a last byte holds in the input register until the result register frees.

module udp_receive_check_demux
    import udp_rcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // seg_byte[7:0], source_addr[39:8],
                                              // dest_addr[71:40]
    input  logic                  s_tlast,    // last_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // slot_hit[1:0], src_port_out[17:2],
                                              // dst_port_out[33:18], payload_len[49:34],
                                              // zero fill [55:50]
    output logic [M_TUSER_W-1:0]  m_tuser,    // verdict[2:0]

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    in_item_t    item;
    logic        item_valid;
    logic        out_free;
    logic        fire;
    logic [15:0] lookup_port;
    port_match_t match;
    result_t     result;

    logic        m_valid_reg;
    result_t     m_data_reg;

    // Only a last byte produces a verdict, so only it needs a free result slot
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = item_valid && (!item.last_byte || out_free);

    udp_rcd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (fire),
        .item       (item),
        .item_valid (item_valid)
    );

    udp_rcd_port_table u_port_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .lookup_port (lookup_port),
        .match       (match)
    );

    udp_rcd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (item),
        .match       (match),
        .lookup_port (lookup_port),
        .result      (result)
    );

    // Result register: load on a last byte, drop once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && item.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && item.last_byte) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.verdict;
    assign m_tdata  = {6'b0, m_data_reg.payload_len, m_data_reg.dst_port_out,
                       m_data_reg.src_port_out, m_data_reg.slot_hit};

`ifndef SYNTHESIS
    // A last byte that fires always leaves a verdict behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_byte |=> m_tvalid)
        else $error("verdict lost after last byte");

    // Never overwrite a verdict that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && item.last_byte && m_valid_reg && !m_tready))
        else $error("pending verdict overwritten");

    // Input stalls only while a byte is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> item_valid)
        else $error("input stalled with empty input register");

    // A too-short segment reports no header ports
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_data_reg.verdict == V_SHORT |->
            m_data_reg.src_port_out == 16'd0 && m_data_reg.dst_port_out == 16'd0)
        else $error("short segment carries ports");
`endif

endmodule
